@@ hdl/mlfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfc_pkg
// shared types and constants of the mesh level-of-detail face collapse block
// ----------------------------------------------------------------------------
`default_nettype none

package mlfc_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_FACES_DEF    = 2048;

  localparam int CORNER_W = 10;
  localparam int INDEX_W  = 11;
  localparam int VCOUNT_W = 11;
  localparam int FCOUNT_W = 12;
  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 12;

  typedef enum logic [1:0] {
    CMD_LOAD_VERTEX = 2'd0,
    CMD_LOAD_FACE   = 2'd1,
    CMD_SET_LEVEL   = 2'd2,
    CMD_READ_FACE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CHAIN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_VERTEX_TOTAL = 2'd0,
    REG_FACE_TOTAL   = 2'd1,
    REG_LOD_STEPS    = 2'd2
  } reg_e;

  typedef struct packed {
    logic                done;
    status_e             status;
    logic [CORNER_W-1:0] vertex;
  } lane_res_t;

  typedef struct packed {
    status_e             status;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
  } merge_res_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_CHECK,
    L_WAIT
  } lane_state_e;

  typedef enum logic [2:0] {
    V_IDLE,
    V_MUL,
    V_PREP,
    V_CHECK,
    V_WAIT
  } lvl_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACE_RD,
    S_LANES,
    S_LEVEL,
    S_DONE
  } top_state_e;

endpackage

`default_nettype wire

@@ hdl/mesh_lod_face_collapse_top.sv @@
// ----------------------------------------------------------------------------
// mesh_lod_face_collapse_top
// progressive mesh level-of-detail engine with three corner collapse lanes
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid_i/in_stall_o  command, index, target, faces, corners, level
// out      out  out_valid_o/out_stall_i collapsed corners, active counts, status
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction at a time; load commands go through S_DONE to the output register
// set level walks down over the dropped vertices, one removed-face read each
// read face follows each corner chain through the lane tables
// reset clears counts and control; tables hold nothing until written
// a new transaction is taken while a result waits under out_stall_i
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_lod_face_collapse_top #(
  parameter int MAX_VERTICES = mlfc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_FACES    = mlfc_pkg::MAX_FACES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [mlfc_pkg::INDEX_W-1:0]  index_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0] collapse_target_i,
  input  wire logic [mlfc_pkg::FCOUNT_W-1:0] faces_removed_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0] corner_a_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0] corner_b_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0] corner_c_i,
  input  wire logic [mlfc_pkg::LEVEL_W-1:0]  lod_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mlfc_pkg::CORNER_W-1:0]      out_corner_a_o,
  output logic [mlfc_pkg::CORNER_W-1:0]      out_corner_b_o,
  output logic [mlfc_pkg::CORNER_W-1:0]      out_corner_c_o,
  output logic [mlfc_pkg::VCOUNT_W-1:0]      active_vertices_o,
  output logic [mlfc_pkg::FCOUNT_W-1:0]      active_faces_o,
  output logic [1:0]                         status_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [mlfc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int FAW = $clog2(MAX_FACES);
  localparam int CW  = mlfc_pkg::CORNER_W;
  localparam int FDW = 3 * CW;

  // configuration
  logic [mlfc_pkg::VCOUNT_W-1:0] vertex_total_q, lod_steps_q;
  logic [mlfc_pkg::FCOUNT_W-1:0] face_total_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_total_q <= '0;
      face_total_q   <= '0;
      lod_steps_q    <= '0;
    end else if (cfg_valid_i) begin
      case (mlfc_pkg::reg_e'(cfg_index_i))
        mlfc_pkg::REG_VERTEX_TOTAL: vertex_total_q <= cfg_data_i[mlfc_pkg::VCOUNT_W-1:0];
        mlfc_pkg::REG_FACE_TOTAL:   face_total_q   <= cfg_data_i;
        mlfc_pkg::REG_LOD_STEPS:    lod_steps_q    <= cfg_data_i[mlfc_pkg::VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  mlfc_pkg::top_state_e state_q, state_d;
  logic in_accept, out_free;
  logic vtx_ok, face_ok, rd_ok;
  logic vtx_wr, face_wr, face_rd, lvl_start, lane_start;
  mlfc_pkg::cmd_e cmd;

  logic [mlfc_pkg::VCOUNT_W-1:0] act_v;
  logic [mlfc_pkg::FCOUNT_W-1:0] act_f;
  logic lvl_done, lanes_done;
  mlfc_pkg::lane_res_t  lane_a, lane_b, lane_c;
  mlfc_pkg::merge_res_t merged;

  logic [FDW-1:0] face_mem [MAX_FACES];
  logic [FDW-1:0] face_rd_q;

  mlfc_pkg::status_e res_status_q;
  logic [CW-1:0]     res_a_q, res_b_q, res_c_q;
  logic              out_valid_q;
  mlfc_pkg::status_e out_status_q;
  logic [CW-1:0]     out_a_q, out_b_q, out_c_q;
  logic [mlfc_pkg::VCOUNT_W-1:0] out_av_q;
  logic [mlfc_pkg::FCOUNT_W-1:0] out_af_q;

  assign cmd       = mlfc_pkg::cmd_e'(command_i);
  assign in_stall_o = (state_q != mlfc_pkg::S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign vtx_ok    = 32'(index_i) < 32'(MAX_VERTICES);
  assign face_ok   = 32'(index_i) < 32'(MAX_FACES);
  assign rd_ok     = face_ok && ({1'b0, index_i} < act_f);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlfc_pkg::S_IDLE: begin
        if (in_accept) begin
          case (cmd)
            mlfc_pkg::CMD_SET_LEVEL: state_d = mlfc_pkg::S_LEVEL;
            mlfc_pkg::CMD_READ_FACE: state_d = rd_ok ? mlfc_pkg::S_FACE_RD : mlfc_pkg::S_DONE;
            default:                 state_d = mlfc_pkg::S_DONE;
          endcase
        end
      end
      mlfc_pkg::S_FACE_RD: state_d = mlfc_pkg::S_LANES;
      mlfc_pkg::S_LANES:   if (lanes_done) state_d = mlfc_pkg::S_DONE;
      mlfc_pkg::S_LEVEL:   if (lvl_done) state_d = mlfc_pkg::S_DONE;
      mlfc_pkg::S_DONE:    if (out_free) state_d = mlfc_pkg::S_IDLE;
      default:             state_d = mlfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    vtx_wr     = 1'b0;
    face_wr    = 1'b0;
    face_rd    = 1'b0;
    lvl_start  = 1'b0;
    lane_start = 1'b0;
    case (state_q)
      mlfc_pkg::S_IDLE: begin
        vtx_wr    = in_accept && (cmd == mlfc_pkg::CMD_LOAD_VERTEX) && vtx_ok;
        face_wr   = in_accept && (cmd == mlfc_pkg::CMD_LOAD_FACE) && face_ok;
        face_rd   = in_accept && (cmd == mlfc_pkg::CMD_READ_FACE) && rd_ok;
        lvl_start = in_accept && (cmd == mlfc_pkg::CMD_SET_LEVEL);
      end
      mlfc_pkg::S_FACE_RD: lane_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (face_wr) face_mem[FAW'(index_i)] <= {corner_a_i, corner_b_i, corner_c_i};
    if (face_rd) face_rd_q <= face_mem[FAW'(index_i)];
  end

  mlfc_level_unit #(.MAX_VERTICES(MAX_VERTICES)) u_level (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (lvl_start),
    .level_i           (lod_level_i),
    .vertex_total_i    (vertex_total_q),
    .face_total_i      (face_total_q),
    .lod_steps_i       (lod_steps_q),
    .wr_en_i           (vtx_wr),
    .wr_addr_i         (AW'(index_i)),
    .wr_data_i         (faces_removed_i),
    .done_o            (lvl_done),
    .active_vertices_o (act_v),
    .active_faces_o    (act_f)
  );

  mlfc_chain_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_a (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (lane_start),
    .corner_i (face_rd_q[FDW-1:2*CW]), .active_i (act_v),
    .wr_en_i (vtx_wr), .wr_addr_i (AW'(index_i)), .wr_data_i (collapse_target_i),
    .res_o (lane_a)
  );

  mlfc_chain_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (lane_start),
    .corner_i (face_rd_q[2*CW-1:CW]), .active_i (act_v),
    .wr_en_i (vtx_wr), .wr_addr_i (AW'(index_i)), .wr_data_i (collapse_target_i),
    .res_o (lane_b)
  );

  mlfc_chain_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_c (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (lane_start),
    .corner_i (face_rd_q[CW-1:0]), .active_i (act_v),
    .wr_en_i (vtx_wr), .wr_addr_i (AW'(index_i)), .wr_data_i (collapse_target_i),
    .res_o (lane_c)
  );

  mlfc_merge u_merge (
    .lane_a_i   (lane_a),
    .lane_b_i   (lane_b),
    .lane_c_i   (lane_c),
    .all_done_o (lanes_done),
    .res_o      (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlfc_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      res_status_q <= mlfc_pkg::ST_OK;
      res_a_q      <= '0;
      res_b_q      <= '0;
      res_c_q      <= '0;
      out_status_q <= mlfc_pkg::ST_OK;
      out_a_q      <= '0;
      out_b_q      <= '0;
      out_c_q      <= '0;
      out_av_q     <= '0;
      out_af_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mlfc_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        mlfc_pkg::S_IDLE: begin
          if (in_accept) begin
            res_a_q      <= '0;
            res_b_q      <= '0;
            res_c_q      <= '0;
            res_status_q <= mlfc_pkg::ST_OK;
            case (cmd)
              mlfc_pkg::CMD_LOAD_VERTEX:
                if (!vtx_ok) res_status_q <= mlfc_pkg::ST_RANGE;
              mlfc_pkg::CMD_LOAD_FACE:
                if (!face_ok) res_status_q <= mlfc_pkg::ST_RANGE;
              mlfc_pkg::CMD_READ_FACE:
                if (!rd_ok) res_status_q <= mlfc_pkg::ST_RANGE;
              default: ;
            endcase
          end
        end
        mlfc_pkg::S_LANES: begin
          if (lanes_done) begin
            res_status_q <= merged.status;
            res_a_q      <= merged.corner_a;
            res_b_q      <= merged.corner_b;
            res_c_q      <= merged.corner_c;
          end
        end
        mlfc_pkg::S_DONE: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_a_q      <= res_a_q;
            out_b_q      <= res_b_q;
            out_c_q      <= res_c_q;
            out_av_q     <= act_v;
            out_af_q     <= act_f;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_corner_a_o    = out_a_q;
  assign out_corner_b_o    = out_b_q;
  assign out_corner_c_o    = out_c_q;
  assign active_vertices_o = out_av_q;
  assign active_faces_o    = out_af_q;
  assign status_o          = out_status_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mlfc_pkg::ST_OK || status_o == mlfc_pkg::ST_RANGE ||
                     status_o == mlfc_pkg::ST_CHAIN))
    else $error("undefined status code");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mlfc_pkg::ST_OK) |->
      (out_corner_a_o == '0 && out_corner_b_o == '0 && out_corner_c_o == '0))
    else $error("corners not cleared on error");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != mlfc_pkg::S_IDLE))
    else $error("accepted transaction left no work");
  a_lanes_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_start |-> $past(face_rd))
    else $error("lanes started without a face read");

endmodule

`default_nettype wire

@@ hdl/mlfc_chain_lane.sv @@
// ----------------------------------------------------------------------------
// mlfc_chain_lane
// follows the collapse chain of one corner through its own copy of the table
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_chain_lane #(
  parameter int MAX_VERTICES = mlfc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0]     corner_i,
  input  wire logic [mlfc_pkg::VCOUNT_W-1:0]     active_i,
  input  wire logic                              wr_en_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   wr_addr_i,
  input  wire logic [mlfc_pkg::CORNER_W-1:0]     wr_data_i,
  output mlfc_pkg::lane_res_t                    res_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);

  logic [mlfc_pkg::CORNER_W-1:0] mem [MAX_VERTICES];
  logic [mlfc_pkg::CORNER_W-1:0] rd_q;

  mlfc_pkg::lane_state_e state_q, state_d;
  logic [mlfc_pkg::CORNER_W-1:0] v_q;
  logic [SW-1:0]                 steps_q;
  logic                          done_q;
  mlfc_pkg::status_e             status_q;

  logic is_done, is_range, is_chain, rd_en;

  assign is_done  = {1'b0, v_q} < active_i;
  assign is_range = 32'(v_q) >= 32'(MAX_VERTICES);
  assign is_chain = 32'(steps_q) >= 32'(MAX_VERTICES);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlfc_pkg::L_IDLE: begin
        if (start_i) state_d = mlfc_pkg::L_CHECK;
      end
      mlfc_pkg::L_CHECK: begin
        if (is_done || is_range || is_chain) state_d = mlfc_pkg::L_IDLE;
        else state_d = mlfc_pkg::L_WAIT;
      end
      mlfc_pkg::L_WAIT: state_d = mlfc_pkg::L_CHECK;
      default: state_d = mlfc_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    case (state_q)
      mlfc_pkg::L_CHECK: rd_en = !(is_done || is_range || is_chain);
      default:           rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en) rd_q <= mem[AW'(v_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mlfc_pkg::L_IDLE;
      done_q   <= 1'b0;
      status_q <= mlfc_pkg::ST_OK;
      v_q      <= '0;
      steps_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mlfc_pkg::L_IDLE: begin
          if (start_i) begin
            v_q     <= corner_i;
            steps_q <= '0;
            done_q  <= 1'b0;
          end
        end
        mlfc_pkg::L_CHECK: begin
          if (is_done) begin
            done_q   <= 1'b1;
            status_q <= mlfc_pkg::ST_OK;
          end else if (is_range) begin
            done_q   <= 1'b1;
            status_q <= mlfc_pkg::ST_RANGE;
          end else if (is_chain) begin
            done_q   <= 1'b1;
            status_q <= mlfc_pkg::ST_CHAIN;
          end
        end
        mlfc_pkg::L_WAIT: begin
          v_q     <= rd_q;
          steps_q <= steps_q + SW'(1);
        end
        default: ;
      endcase
    end
  end

  assign res_o.done   = done_q;
  assign res_o.status = status_q;
  assign res_o.vertex = v_q;

  a_ok_below_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlfc_pkg::L_CHECK && is_done) |=> ({1'b0, v_q} < active_i))
    else $error("lane finished ok above active count");
  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(steps_q) <= 32'(MAX_VERTICES))
    else $error("lane step count overran");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlfc_pkg::L_IDLE && start_i) |=> !done_q)
    else $error("lane done flag not cleared on start");

endmodule

`default_nettype wire

@@ hdl/mlfc_level_unit.sv @@
// ----------------------------------------------------------------------------
// mlfc_level_unit
// turns a detail level into active vertex and face counts
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_level_unit #(
  parameter int MAX_VERTICES = mlfc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [mlfc_pkg::LEVEL_W-1:0]    level_i,
  input  wire logic [mlfc_pkg::VCOUNT_W-1:0]   vertex_total_i,
  input  wire logic [mlfc_pkg::FCOUNT_W-1:0]   face_total_i,
  input  wire logic [mlfc_pkg::VCOUNT_W-1:0]   lod_steps_i,
  input  wire logic                            wr_en_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_addr_i,
  input  wire logic [mlfc_pkg::FCOUNT_W-1:0]   wr_data_i,
  output logic                                 done_o,
  output logic [mlfc_pkg::VCOUNT_W-1:0]        active_vertices_o,
  output logic [mlfc_pkg::FCOUNT_W-1:0]        active_faces_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = mlfc_pkg::VCOUNT_W;
  localparam int FW = mlfc_pkg::FCOUNT_W;
  localparam int PW = 28;

  logic [FW-1:0] mem [MAX_VERTICES];
  logic [FW-1:0] rd_q;

  mlfc_pkg::lvl_state_e state_q, state_d;
  logic [mlfc_pkg::LEVEL_W-1:0] level_q;
  logic [PW-1:0] prod_q;
  logic [VW-1:0] vt_q, new_act_q, walk_q, act_q;
  logic [FW-1:0] work_q, faces_q;

  logic [16:0]   span;
  logic [11:0]   dropped;
  logic [VW-1:0] vt_d;
  logic          more, rd_en;

  assign span    = (level_q == 16'hFFFF) ? 17'd0 : (17'h10000 - {1'b0, level_q});
  assign dropped = prod_q[PW-1:16];
  assign vt_d    = (32'(vertex_total_i) > 32'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                             : vertex_total_i;
  assign more    = walk_q > new_act_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlfc_pkg::V_IDLE:  if (start_i) state_d = mlfc_pkg::V_MUL;
      mlfc_pkg::V_MUL:   state_d = mlfc_pkg::V_PREP;
      mlfc_pkg::V_PREP:  state_d = mlfc_pkg::V_CHECK;
      mlfc_pkg::V_CHECK: state_d = more ? mlfc_pkg::V_WAIT : mlfc_pkg::V_IDLE;
      mlfc_pkg::V_WAIT:  state_d = mlfc_pkg::V_CHECK;
      default:           state_d = mlfc_pkg::V_IDLE;
    endcase
  end

  always_comb begin
    rd_en  = 1'b0;
    done_o = 1'b0;
    case (state_q)
      mlfc_pkg::V_CHECK: begin
        rd_en  = more;
        done_o = !more;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en) rd_q <= mem[AW'(walk_q - VW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mlfc_pkg::V_IDLE;
      act_q     <= '0;
      faces_q   <= '0;
      level_q   <= '0;
      prod_q    <= '0;
      vt_q      <= '0;
      new_act_q <= '0;
      walk_q    <= '0;
      work_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mlfc_pkg::V_IDLE: if (start_i) level_q <= level_i;
        mlfc_pkg::V_MUL: begin
          prod_q <= PW'({11'd0, span} * {17'd0, lod_steps_i});
          vt_q   <= vt_d;
        end
        mlfc_pkg::V_PREP: begin
          new_act_q <= (dropped > {1'b0, vt_q}) ? '0 : (vt_q - dropped[VW-1:0]);
          walk_q    <= vt_q;
          work_q    <= face_total_i;
        end
        mlfc_pkg::V_CHECK: begin
          if (!more) begin
            act_q   <= new_act_q;
            faces_q <= work_q;
          end
        end
        mlfc_pkg::V_WAIT: begin
          work_q <= (rd_q > work_q) ? '0 : (work_q - rd_q);
          walk_q <= walk_q - VW'(1);
        end
        default: ;
      endcase
    end
  end

  assign active_vertices_o = act_q;
  assign active_faces_o    = faces_q;

  a_walk_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlfc_pkg::V_WAIT) |-> (walk_q > new_act_q))
    else $error("level walk went below active count");
  a_act_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(act_q) <= 32'(MAX_VERTICES))
    else $error("active vertex count above table depth");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == mlfc_pkg::V_IDLE))
    else $error("level unit did not return to idle");

endmodule

`default_nettype wire

@@ hdl/mlfc_merge.sv @@
// ----------------------------------------------------------------------------
// mlfc_merge
// combines the three lane results, first error in corner order wins
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_merge (
  input  mlfc_pkg::lane_res_t  lane_a_i,
  input  mlfc_pkg::lane_res_t  lane_b_i,
  input  mlfc_pkg::lane_res_t  lane_c_i,
  output logic                 all_done_o,
  output mlfc_pkg::merge_res_t res_o
);

  always_comb begin
    all_done_o     = lane_a_i.done & lane_b_i.done & lane_c_i.done;
    res_o.corner_a = '0;
    res_o.corner_b = '0;
    res_o.corner_c = '0;
    if (lane_a_i.status != mlfc_pkg::ST_OK) begin
      res_o.status = lane_a_i.status;
    end else if (lane_b_i.status != mlfc_pkg::ST_OK) begin
      res_o.status = lane_b_i.status;
    end else if (lane_c_i.status != mlfc_pkg::ST_OK) begin
      res_o.status = lane_c_i.status;
    end else begin
      res_o.status   = mlfc_pkg::ST_OK;
      res_o.corner_a = lane_a_i.vertex;
      res_o.corner_b = lane_b_i.vertex;
      res_o.corner_c = lane_c_i.vertex;
    end
  end

endmodule

`default_nettype wire
